### rtl/bole_pkg.sv
`default_nettype none

package bole_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int VALUE_W       = 32;
   localparam int POS_W         = 8;

   // operation codes of an input item
   localparam logic [1:0] OP_INS_FRONT = 2'd0;
   localparam logic [1:0] OP_INS_END   = 2'd1;
   localparam logic [1:0] OP_DELETE    = 2'd2;
   localparam logic [1:0] OP_READ_ALL  = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;
   localparam logic [1:0] ST_BADPOS = 2'd3;

endpackage

`default_nettype wire

### rtl/bole_ram.sv
`default_nettype none

module bole_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/bounded_ordered_list_engine_unit.sv
// Ordered list of up to DEPTH signed 32-bit values, kept as a circular buffer
// (head pointer plus entry count) in a single-port-write, single-port-read RAM.
// Input channel req_*: op selects insert front, insert end, delete at a 1-based
// position, or read all; value and position are used by the ops that need them.
// Result channel rsp_*: inserts and deletes give one item; read-all gives one
// item per entry in list order, or one item with status empty for an empty list.
// rsp_last marks the final item caused by each request.
// Sequencing (one request at a time, req_ready only while idle):
//   insert front/end: RAM write in S_EXEC, result through S_FINISH
//   delete at position p: one RAM read (S_DEL_RD) and one write (S_DEL_WR)
//   per moved entry through the shared address adder
//   read-all: one entry per cycle while the receiver is ready, paced by the
//   registered RAM read
// The result register lets the next request be accepted while the last result
// still waits. A stalled receiver holds the sequencer at its next result.
// Reset empties the list (count and head cleared); RAM contents are not cleared.
`default_nettype none

module bounded_ordered_list_engine_unit #(
   parameter int DEPTH = bole_pkg::DEPTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [1:0]                       req_op,
   input  wire logic signed [bole_pkg::VALUE_W-1:0] req_value,
   input  wire logic [bole_pkg::POS_W-1:0]       req_position,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic signed [bole_pkg::VALUE_W-1:0]   rsp_entry_value,
   output logic [$clog2(DEPTH+1)-1:0]            rsp_entry_index,
   output logic [1:0]                            rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]            rsp_entry_count,
   output logic                                  rsp_last
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int CMP_W = (CNT_W > bole_pkg::POS_W) ? CNT_W : bole_pkg::POS_W;
   localparam int VW    = bole_pkg::VALUE_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_DEL_RD,
      S_DEL_WR,
      S_STREAM,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [1:0]       op_ff, op_in;
   logic [VW-1:0]    value_ff, value_in;
   logic [bole_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [1:0]       status_ff, status_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]    rsp_value_ff, rsp_value_in;
   logic [CNT_W-1:0] rsp_index_ff, rsp_index_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             out_free;
   logic             full;
   logic             pos_bad;
   logic [CMP_W-1:0] pos_wide;
   logic [CNT_W-1:0] del_offset;
   logic [PTR_W-1:0] head_dec;
   logic [CNT_W-1:0] offset;
   logic [SUM_W-1:0] sum;
   logic [PTR_W-1:0] addr;
   logic [CNT_W-1:0] idx_next;

   logic             ram_we;
   logic [PTR_W-1:0] ram_waddr;
   logic [VW-1:0]    ram_wdata;
   logic [VW-1:0]    ram_rdata;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign pos_wide   = CMP_W'(pos_ff);
   assign pos_bad    = (pos_ff == '0) || (pos_wide > CMP_W'(count_ff));
   assign del_offset = CNT_W'(pos_wide - CMP_W'(1));
   assign head_dec   = (head_ff == '0) ? PTR_W'(DEPTH - 1) : head_ff - PTR_W'(1);
   assign idx_next   = idx_ff + CNT_W'(1);

   // shared address unit: head plus logical offset, wrapped once
   assign sum  = SUM_W'(head_ff) + SUM_W'(offset);
   assign addr = (sum >= SUM_W'(DEPTH)) ? PTR_W'(sum - SUM_W'(DEPTH)) : PTR_W'(sum);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      pos_in        = pos_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      offset        = idx_ff;
      ram_we        = 1'b0;
      ram_waddr     = addr;
      ram_wdata     = value_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               value_in = req_value;
               pos_in   = req_position;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = bole_pkg::ST_OK;
            state_in  = S_FINISH;
            case (op_ff)
               bole_pkg::OP_INS_FRONT: begin
                  if (full) begin
                     status_in = bole_pkg::ST_FULL;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = head_dec;
                     head_in   = head_dec;
                     count_in  = count_ff + CNT_W'(1);
                  end
               end
               bole_pkg::OP_INS_END: begin
                  offset = count_ff;
                  if (full) begin
                     status_in = bole_pkg::ST_FULL;
                  end else begin
                     ram_we   = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               bole_pkg::OP_DELETE: begin
                  if (count_ff == '0) begin
                     status_in = bole_pkg::ST_EMPTY;
                  end else if (pos_bad) begin
                     status_in = bole_pkg::ST_BADPOS;
                  end else if (del_offset == count_ff - CNT_W'(1)) begin
                     // tail entry: nothing to move
                     count_in = count_ff - CNT_W'(1);
                  end else begin
                     idx_in   = del_offset;
                     state_in = S_DEL_RD;
                  end
               end
               default: begin
                  // read all: present the first entry's address now
                  offset = '0;
                  if (count_ff == '0) begin
                     status_in = bole_pkg::ST_EMPTY;
                  end else begin
                     idx_in   = '0;
                     state_in = S_STREAM;
                  end
               end
            endcase
         end
         S_DEL_RD: begin
            offset   = idx_next;
            state_in = S_DEL_WR;
         end
         S_DEL_WR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            idx_in    = idx_next;
            if (SUM_W'(idx_ff) + SUM_W'(2) >= SUM_W'(count_ff)) begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_FINISH;
            end else begin
               state_in = S_DEL_RD;
            end
         end
         S_STREAM: begin
            // hold the read address until the output register takes the entry
            if (out_free) begin
               offset        = idx_next;
               rsp_valid_in  = 1'b1;
               rsp_value_in  = ram_rdata;
               rsp_index_in  = idx_next;
               rsp_status_in = bole_pkg::ST_OK;
               rsp_count_in  = count_ff;
               rsp_last_in   = (idx_next == count_ff);
               idx_in        = idx_next;
               if (idx_next == count_ff) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_index_in  = '0;
               rsp_status_in = status_ff;
               rsp_count_in  = count_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      op_ff         <= op_in;
      value_ff      <= value_in;
      pos_ff        <= pos_in;
      status_ff     <= status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   bole_ram #(
      .WIDTH (VW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (addr),
      .rd_data (ram_rdata)
   );

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_entry_index = rsp_index_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      SUM_W'(head_ff) < SUM_W'(DEPTH))
      else $error("head pointer out of range");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_index_in_list: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_entry_index != '0) |->
         (rsp_status == bole_pkg::ST_OK) && (rsp_entry_index <= rsp_entry_count))
      else $error("read-out index outside list");

   a_last_at_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_entry_index != '0) && (rsp_entry_index == rsp_entry_count)
         |-> rsp_last)
      else $error("final entry not marked last");

endmodule

`default_nettype wire

### dv/bounded_ordered_list_engine_unit_test.sv
`default_nettype none

module bounded_ordered_list_engine_unit_test;

   localparam int DEPTH   = bole_pkg::DEPTH_DEFAULT;
   localparam int VALUE_W = bole_pkg::VALUE_W;
   localparam int POS_W   = bole_pkg::POS_W;
   localparam int CW      = $clog2(DEPTH + 1);
   localparam int QUIET_TAIL = 60;

   typedef struct {
      logic [1:0]                op;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
   } list_req_type;

   typedef struct {
      logic signed [VALUE_W-1:0] entry_value;
      logic [CW-1:0]             entry_index;
      logic [1:0]                status;
      logic [CW-1:0]             entry_count;
      logic                      last;
   } list_result_type;

   logic                      clock        = 1'b0;
   logic                      reset        = 1'b1;
   logic                      req_valid    = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_op       = bole_pkg::OP_INS_FRONT;
   logic signed [VALUE_W-1:0] req_value    = '0;
   logic [POS_W-1:0]          req_position = '0;
   logic                      rsp_valid;
   logic                      rsp_ready    = 1'b0;
   logic signed [VALUE_W-1:0] rsp_entry_value;
   logic [CW-1:0]             rsp_entry_index;
   logic [1:0]                rsp_status;
   logic [CW-1:0]             rsp_entry_count;
   logic                      rsp_last;

   bounded_ordered_list_engine_unit #(.DEPTH(DEPTH)) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_entry_value (rsp_entry_value),
      .rsp_entry_index (rsp_entry_index),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_last        (rsp_last)
   );

   always #1 clock = ~clock;

   list_req_type              req_backlog[$];
   list_result_type           awaited_results[$];
   logic signed [VALUE_W-1:0] list_vals[DEPTH];
   int unsigned               list_len = 0;
   int unsigned               plan_len = 0;
   int unsigned               fail_count = 0;
   int unsigned               total_planned = 0;
   int unsigned               issued = 0;
   logic                      req_taken = 1'b0;

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t: %s", $time, msg);
   endtask

   // shadow list: computes what the block must answer for one accepted item
   task automatic apply_list_op(input list_req_type r);
      list_result_type res;
      int unsigned     i;
      res.entry_value = '0;
      res.entry_index = '0;
      res.status      = bole_pkg::ST_OK;
      res.last        = 1'b1;
      case (r.op)
         bole_pkg::OP_INS_FRONT, bole_pkg::OP_INS_END: begin
            if (list_len >= DEPTH) begin
               res.status = bole_pkg::ST_FULL;
            end else begin
               if (r.op == bole_pkg::OP_INS_FRONT) begin
                  for (i = list_len; i > 0; i--)
                     list_vals[i] = list_vals[i-1];
                  list_vals[0] = r.value;
               end else begin
                  list_vals[list_len] = r.value;
               end
               list_len++;
            end
            res.entry_count = CW'(list_len);
            awaited_results.push_back(res);
         end
         bole_pkg::OP_DELETE: begin
            if (list_len == 0) begin
               res.status = bole_pkg::ST_EMPTY;
            end else if (r.position == 0 || r.position > list_len) begin
               res.status = bole_pkg::ST_BADPOS;
            end else begin
               for (i = r.position - 1; i + 1 < list_len; i++)
                  list_vals[i] = list_vals[i+1];
               list_len--;
            end
            res.entry_count = CW'(list_len);
            awaited_results.push_back(res);
         end
         default: begin
            res.entry_count = CW'(list_len);
            if (list_len == 0) begin
               res.status = bole_pkg::ST_EMPTY;
               awaited_results.push_back(res);
            end else begin
               for (i = 0; i < list_len; i++) begin
                  res.entry_value = list_vals[i];
                  res.entry_index = CW'(i + 1);
                  res.last        = (i + 1 == list_len);
                  awaited_results.push_back(res);
               end
            end
         end
      endcase
   endtask

   // monitor: predicts on accepted requests, checks accepted results
   always @(posedge clock) begin
      list_result_type exp;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready)
            apply_list_op('{op: req_op, value: req_value, position: req_position});
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               note_failure($sformatf(
                  "result with nothing awaited: val=%0d idx=%0d st=%0d cnt=%0d last=%0b",
                  rsp_entry_value, rsp_entry_index, rsp_status, rsp_entry_count, rsp_last));
            end else begin
               exp = awaited_results.pop_front();
               if (rsp_entry_value !== exp.entry_value || rsp_entry_index !== exp.entry_index ||
                   rsp_status !== exp.status || rsp_entry_count !== exp.entry_count ||
                   rsp_last !== exp.last)
                  note_failure({
                     $sformatf("mismatch: expected val=%0d idx=%0d st=%0d cnt=%0d last=%0b",
                        exp.entry_value, exp.entry_index, exp.status, exp.entry_count,
                        exp.last),
                     $sformatf(", got val=%0d idx=%0d st=%0d cnt=%0d last=%0b",
                        rsp_entry_value, rsp_entry_index, rsp_status, rsp_entry_count,
                        rsp_last)});
            end
         end
      end
   end

   // request driver with random gaps between items, result receiver with random stalls
   int unsigned req_gap = 0;
   int unsigned req_mode = 0;
   int unsigned rsp_stall = 0;
   int unsigned rsp_mode = 0;
   int unsigned cyc = 0;

   function automatic bit start_idle(input int unsigned mode);
      bit quiet;
      quiet = (issued + QUIET_TAIL >= total_planned);
      if (quiet || mode == 0)
         return 1'b0;
      return (mode == 1) ? ($urandom_range(0, 15) == 0) : ($urandom_range(0, 3) == 0);
   endfunction

   always @(negedge clock) begin
      list_req_type r;
      if (!reset) begin
         cyc <= cyc + 1;
         // idling intensity changes every so often, calm stretches included
         if (cyc % 97 == 0) begin
            req_mode <= $urandom_range(0, 2);
            rsp_mode <= $urandom_range(0, 2);
         end
         if (!req_valid || req_taken) begin
            if (req_gap > 0) begin
               req_gap   <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               r = req_backlog.pop_front();
               req_op       <= r.op;
               req_value    <= r.value;
               req_position <= r.position;
               req_valid    <= 1'b1;
               issued       <= issued + 1;
               if (start_idle(req_mode))
                  req_gap <= $urandom_range(1, 10);
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (start_idle(rsp_mode))
               rsp_stall <= $urandom_range(1, 10);
         end
      end
   end

   task automatic plan_item(input logic [1:0] op, input logic signed [VALUE_W-1:0] value,
                            input logic [POS_W-1:0] position);
      req_backlog.push_back('{op: op, value: value, position: position});
      // track the list size so random deletes can aim at real entries
      if ((op == bole_pkg::OP_INS_FRONT || op == bole_pkg::OP_INS_END) && plan_len < DEPTH)
         plan_len++;
      else if (op == bole_pkg::OP_DELETE && plan_len > 0 && position >= 1 &&
               position <= plan_len)
         plan_len--;
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [POS_W-1:0] pick_position();
      if (plan_len > 0 && $urandom_range(0, 9) < 7)
         return POS_W'($urandom_range(1, plan_len));
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return POS_W'(plan_len + 1);
         2:       return '1;
         default: return POS_W'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      int unsigned seg;
      int unsigned k;
      int unsigned roll;
      int unsigned n;
      bit          grow;

      // empty list corners, extreme values, bad positions, removing the sole entry
      plan_item(bole_pkg::OP_READ_ALL,  '0, '0);
      plan_item(bole_pkg::OP_DELETE,    '0, 8'd1);
      plan_item(bole_pkg::OP_INS_FRONT, 32'sh7FFF_FFFF, '0);
      plan_item(bole_pkg::OP_INS_END,   32'sh8000_0000, '1);
      plan_item(bole_pkg::OP_INS_FRONT, '0, '0);
      plan_item(bole_pkg::OP_INS_END,   -32'sd1, '0);
      plan_item(bole_pkg::OP_READ_ALL,  '0, '0);
      plan_item(bole_pkg::OP_DELETE,    '0, 8'd0);
      plan_item(bole_pkg::OP_DELETE,    '0, 8'd5);
      plan_item(bole_pkg::OP_DELETE,    '0, 8'd255);
      plan_item(bole_pkg::OP_DELETE,    '0, 8'd4);
      plan_item(bole_pkg::OP_DELETE,    '0, 8'd1);
      plan_item(bole_pkg::OP_READ_ALL,  '0, '0);
      plan_item(bole_pkg::OP_DELETE,    '0, 8'd2);
      plan_item(bole_pkg::OP_DELETE,    '0, 8'd1);
      plan_item(bole_pkg::OP_READ_ALL,  '0, '0);
      plan_item(bole_pkg::OP_INS_END,   32'sh5555_5555, '0);
      plan_item(bole_pkg::OP_INS_FRONT, 32'shAAAA_AAAA, '0);
      plan_item(bole_pkg::OP_READ_ALL,  '0, '0);

      // random part: alternate growing and shrinking so full and empty are both hit
      for (seg = 0; seg < 12; seg++) begin
         grow = (seg % 2 == 0);
         n = $urandom_range(30, 46);
         for (k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < (grow ? 40 : 12))
               plan_item(bole_pkg::OP_INS_FRONT, pick_value(),
                         POS_W'($urandom_range(0, 255)));
            else if (roll < (grow ? 75 : 24))
               plan_item(bole_pkg::OP_INS_END, pick_value(),
                         POS_W'($urandom_range(0, 255)));
            else if (roll < (grow ? 88 : 80))
               plan_item(bole_pkg::OP_DELETE, pick_value(), pick_position());
            else
               plan_item(bole_pkg::OP_READ_ALL, pick_value(),
                         POS_W'($urandom_range(0, 255)));
         end
      end
      plan_item(bole_pkg::OP_READ_ALL, '0, '0);
      total_planned = req_backlog.size();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      do @(posedge clock); while (req_backlog.size() != 0 || req_valid);
      for (k = 0; k < 20000 && awaited_results.size() != 0; k++)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (awaited_results.size() != 0)
         note_failure($sformatf("%0d results never arrived", awaited_results.size()));

      if (fail_count == 0)
         $display("** bounded_ordered_list_engine_unit: PASSED **");
      else
         $display("** bounded_ordered_list_engine_unit: FAILED **");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("** bounded_ordered_list_engine_unit: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
